// ----- hdl/websocket_frame_receiver_macros.svh -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver assertion macros
// Shared property forms for the frame receiver checkers.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled in reset
`define WFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// next-cycle implication, disabled in reset
`define WFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

// ----- hdl/wfr_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Result word type, status codes, opcodes and header constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wfr_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_BAD_OPCODE = 2'd1;
    localparam status_t ST_TOO_BIG    = 2'd2;
    localparam status_t ST_CLOSE      = 2'd3;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [3:0] frame_opcode;
        logic       last_of_frame;
        status_t    status;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/websocket_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Parses a received byte stream into unmasked payload words and status words.
// ----------------------------------------------------------------------------
//   channel   signals                          direction
//   input     in_valid, in_stall, rx_byte      in  (one stream byte a word)
//   output    out_valid, out_stall, fields     out (zero or one word a byte)
//   config    cfg_write, cfg_data              in  (max_payload)
//
// A byte is taken every cycle while in_stall is low, and each result loads
// the output register in the cycle after its byte. Reset sets max_payload
// to 65536 and opens the stream at the first header byte. in_stall rises
// only while a result waits and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_receiver #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic [3:0]       frame_opcode,
    output logic             last_of_frame,
    output logic [1:0]       status
);

    logic             take;
    logic             res_push;
    logic             full_stalled;
    wfr_pkg::result_t res;
    wfr_pkg::result_t res_out;

    assign in_stall = full_stalled;
    assign take     = in_valid && !full_stalled;

    wfr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .take      (take),
        .rx_byte   (rx_byte),
        .res_push  (res_push),
        .res       (res)
    );

    wfr_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (res_push),
        .res          (res),
        .out_stall    (out_stall),
        .full_stalled (full_stalled),
        .out_valid    (out_valid),
        .res_out      (res_out)
    );

    assign payload_byte  = res_out.payload_byte;
    assign byte_valid    = res_out.byte_valid;
    assign frame_opcode  = res_out.frame_opcode;
    assign last_of_frame = res_out.last_of_frame;
    assign status        = res_out.status;

endmodule

`default_nettype wire

// ----- hdl/wfr_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Header state machine, length check and payload unmasking, one byte a cycle on take.
// ----------------------------------------------------------------------------
`default_nettype none

module wfr_parser #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [31:0]      cfg_data,
    input  wire logic             take,
    input  wire logic [7:0]       rx_byte,
    output logic                  res_push,
    output wfr_pkg::result_t      res
);

    localparam int CMP_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [3:0]               opcode_reg, opcode_next;
    logic                     masked_reg, masked_next;
    logic [3:0]               left_reg, left_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic                     ovf_reg, ovf_next;
    logic [31:0]              key_reg, key_next;
    logic [1:0]               kidx_reg, kidx_next;
    logic                     closed_reg, closed_next;
    logic [31:0]              max_reg;

    logic [3:0]               op_in;
    logic [LENGTH_BITS-1:0]   len_shift;
    logic                     ovf_shift;
    logic [LENGTH_BITS-1:0]   len_dec;
    logic [7:0]               key_byte;
    logic                     emit;
    wfr_pkg::result_t         r;

    // length check against the configured limit, also failing on overflow
    function automatic logic too_big(input logic [LENGTH_BITS-1:0] len, input logic ovf,
                                     input logic [31:0] lim);
        return ovf || (CMP_W'(len) > CMP_W'(lim));
    endfunction

    assign op_in     = rx_byte[3:0];
    assign len_shift = {len_reg[LENGTH_BITS-9:0], rx_byte};
    assign ovf_shift = ovf_reg || (len_reg[LENGTH_BITS-1:LENGTH_BITS-8] != 8'd0);
    assign len_dec   = len_reg - LENGTH_BITS'(1);

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        left_next   = left_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        closed_next = closed_reg;
        emit        = 1'b0;
        r.payload_byte  = 8'd0;
        r.byte_valid    = 1'b0;
        r.frame_opcode  = opcode_reg;
        r.last_of_frame = 1'b0;
        r.status        = wfr_pkg::ST_OK;

        if (take && !closed_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next    = op_in;
                    r.frame_opcode = op_in;
                    if (op_in == wfr_pkg::OP_CLOSE)
                    begin
                        closed_next = 1'b1;
                        emit        = 1'b1;
                        r.status    = wfr_pkg::ST_CLOSE;
                    end
                    else if (op_in != wfr_pkg::OP_CONT && op_in != wfr_pkg::OP_TEXT &&
                             op_in != wfr_pkg::OP_BINARY && op_in != wfr_pkg::OP_PING &&
                             op_in != wfr_pkg::OP_PONG)
                    begin
                        closed_next = 1'b1;
                        emit        = 1'b1;
                        r.status    = wfr_pkg::ST_BAD_OPCODE;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    ovf_next    = 1'b0;
                    if (rx_byte[6:0] == wfr_pkg::LEN_EXT16)
                    begin
                        len_next   = '0;
                        left_next  = wfr_pkg::EXT16_BYTES;
                        phase_next = PH_EXT;
                    end
                    else if (rx_byte[6:0] == wfr_pkg::LEN_EXT64)
                    begin
                        len_next   = '0;
                        left_next  = wfr_pkg::EXT64_BYTES;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        len_next = LENGTH_BITS'(rx_byte[6:0]);
                        if (too_big(LENGTH_BITS'(rx_byte[6:0]), 1'b0, max_reg))
                        begin
                            closed_next = 1'b1;
                            emit        = 1'b1;
                            r.status    = wfr_pkg::ST_TOO_BIG;
                        end
                        else if (rx_byte[7])
                        begin
                            left_next  = wfr_pkg::KEY_BYTES;
                            key_next   = '0;
                            phase_next = PH_KEY;
                        end
                        else if (rx_byte[6:0] == 7'd0)
                        begin
                            emit            = 1'b1;
                            r.last_of_frame = 1'b1;
                            phase_next      = PH_HDR0;
                        end
                        else
                        begin
                            kidx_next  = 2'd0;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_EXT:
                begin
                    len_next  = len_shift;
                    ovf_next  = ovf_shift;
                    left_next = left_reg - 4'd1;
                    if (left_reg == 4'd1)
                    begin
                        if (too_big(len_shift, ovf_shift, max_reg))
                        begin
                            closed_next = 1'b1;
                            emit        = 1'b1;
                            r.status    = wfr_pkg::ST_TOO_BIG;
                        end
                        else if (masked_reg)
                        begin
                            left_next  = wfr_pkg::KEY_BYTES;
                            key_next   = '0;
                            phase_next = PH_KEY;
                        end
                        else if (len_shift == '0)
                        begin
                            emit            = 1'b1;
                            r.last_of_frame = 1'b1;
                            phase_next      = PH_HDR0;
                        end
                        else
                        begin
                            kidx_next  = 2'd0;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next  = {key_reg[23:0], rx_byte};
                    left_next = left_reg - 4'd1;
                    if (left_reg == 4'd1)
                    begin
                        if (len_reg == '0)
                        begin
                            emit            = 1'b1;
                            r.last_of_frame = 1'b1;
                            phase_next      = PH_HDR0;
                        end
                        else
                        begin
                            kidx_next  = 2'd0;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    emit           = 1'b1;
                    r.byte_valid   = 1'b1;
                    r.payload_byte = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                    kidx_next      = kidx_reg + 2'd1;
                    len_next       = len_dec;
                    if (len_dec == '0)
                    begin
                        r.last_of_frame = 1'b1;
                        phase_next      = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    assign res_push = emit;
    assign res      = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= 4'd0;
            masked_reg <= 1'b0;
            left_reg   <= 4'd0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            key_reg    <= 32'd0;
            kidx_reg   <= 2'd0;
            closed_reg <= 1'b0;
            max_reg    <= wfr_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            left_reg   <= left_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            closed_reg <= closed_next;
            if (cfg_write)
            begin
                max_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/wfr_out_reg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wfr_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wfr_pkg::result_t  res,
    input  wire logic              out_stall,
    output logic                   full_stalled,
    output logic                   out_valid,
    output wfr_pkg::result_t       res_out
);

    logic             valid_reg, valid_next;
    wfr_pkg::result_t data_reg;

    // hold while stalled, load a new word on push
    assign valid_next   = push || (valid_reg && out_stall);
    assign full_stalled = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

`default_nettype wire

// ----- hdl/wfr_checker.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver checker
// Port-level properties of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_receiver_macros.svh"

module wfr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] payload_byte,
    input wire logic       byte_valid,
    input wire logic [3:0] frame_opcode,
    input wire logic       last_of_frame,
    input wire logic [1:0] status
);

    logic [15:0] out_word;
    logic        status_word;
    logic        blank_word;

    assign out_word    = {payload_byte, byte_valid, frame_opcode, last_of_frame, status};
    assign status_word = out_valid && (status != wfr_pkg::ST_OK);
    assign blank_word  = !byte_valid && !last_of_frame && (payload_byte == 8'd0);

    `WFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))
    `WFR_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    `WFR_ASSERT_SAME(a_status_shape, clk, rst_n, status_word, blank_word)
    `WFR_ASSERT_NEXT(a_closed_quiet, clk, rst_n, status_word && !out_stall, !out_valid)

endmodule

bind websocket_frame_receiver wfr_checker u_wfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .byte_valid    (byte_valid),
    .frame_opcode  (frame_opcode),
    .last_of_frame (last_of_frame),
    .status        (status)
);

`default_nettype wire
